[design/lru_memo_cache_core_defines.svh]
// Assertion macros for the cache checker file
`ifndef LRU_MEMO_CACHE_CORE_DEFINES_SVH
`define LRU_MEMO_CACHE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define LMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define LMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/lmc_pkg.sv]
// Shared constants and item types for the LRU memo cache
`timescale 1ns / 1ps
`default_nettype none

package lmc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;

  localparam int RANK_W = $clog2(MAX_ENTRIES);
  localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);

  // capacity register
  localparam int             CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // stream widths, whole bytes
  localparam int IN_TDATA_W  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VALUE_BITS + KEY_BITS + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] fill;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] value;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;
  } rsp_t;

endpackage

`default_nettype wire

[design/lru_memo_cache_core.sv]
// Top level of the LRU memo cache: input register, lookup, result register
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata: lookup_key, fill_value
//  out_    | out | out_tvalid/tready  | tdata: result_value, evicted_key;
//          |     |                    | tuser: hit, evicted
//  cfg_    | in  | cfg_wr_en          | cfg_wr_data: capacity
//
// One item per cycle sustained while the output is not stalled; an accepted item
// moves from the input register into the result register, where out_tvalid rises.
// The tag compare and rank update over all entries sit between the input
// register and the result register. Reset clears all entries and sets
// capacity to 16. An output stall backs up into the input register, and
// in_tready drops only when both registers are full and out_tready is low.
`timescale 1ns / 1ps
`default_nettype none

module lru_memo_cache_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in channel
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [lmc_pkg::IN_TDATA_W-1:0]    in_tdata,   // lookup_key, fill_value
  // out channel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [lmc_pkg::OUT_TDATA_W-1:0]        out_tdata,  // result_value, evicted_key
  output logic [lmc_pkg::OUT_TUSER_W-1:0]        out_tuser,  // hit, evicted
  // configuration
  input  wire logic                              cfg_wr_en,
  input  wire logic [lmc_pkg::CAP_W-1:0]         cfg_wr_data // capacity
);

  logic          s1_vld_r;
  lmc_pkg::req_t s1_req_r;
  logic          out_vld_r;
  lmc_pkg::rsp_t out_rsp_r;
  lmc_pkg::rsp_t rsp;
  logic          s1_adv;
  logic          in_fire;

  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  lmc_lookup u_lookup (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (s1_req_r),
    .commit      (s1_adv),
    .rsp         (rsp)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_fire) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r.key  <= in_tdata[lmc_pkg::KEY_BITS-1:0];
      s1_req_r.fill <= in_tdata[lmc_pkg::KEY_BITS +: lmc_pkg::VALUE_BITS];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = lmc_pkg::OUT_TDATA_W'({out_rsp_r.evicted_key, out_rsp_r.value});
  assign out_tuser  = {out_rsp_r.evicted, out_rsp_r.hit};

endmodule

`default_nettype wire

[design/lmc_lookup.sv]
// Entry store, tag compare and recency update of the LRU memo cache
`timescale 1ns / 1ps
`default_nettype none

module lmc_lookup (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [lmc_pkg::CAP_W-1:0]  cfg_wr_data,
  input  wire lmc_pkg::req_t              req,
  input  wire logic                       commit,
  output lmc_pkg::rsp_t                   rsp
);

  localparam int N = lmc_pkg::MAX_ENTRIES;

  logic [lmc_pkg::KEY_BITS-1:0]   key_r   [N];
  logic [lmc_pkg::VALUE_BITS-1:0] value_r [N];
  logic [N-1:0]                   valid_r, valid_nxt;
  logic [lmc_pkg::RANK_W-1:0]     rank_r  [N];
  logic [lmc_pkg::RANK_W-1:0]     rank_nxt[N];
  logic [lmc_pkg::OCC_W-1:0]      occ_r, occ_nxt;
  logic [lmc_pkg::CAP_W-1:0]      cap_r;

  logic [lmc_pkg::OCC_W-1:0]      eff_cap;
  logic [lmc_pkg::RANK_W-1:0]     lru_rank;
  logic [lmc_pkg::RANK_W-1:0]     hit_rank;
  logic [N-1:0]                   hit_oh, victim_oh, free_oh, slot_oh;
  logic                           hit, evict;
  logic [lmc_pkg::VALUE_BITS-1:0] hit_value;
  logic [lmc_pkg::KEY_BITS-1:0]   victim_key;

  // clamp capacity to 1..MAX_ENTRIES
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = lmc_pkg::OCC_W'(1);
    end else if (int'(cap_r) > N) begin
      eff_cap = lmc_pkg::OCC_W'(N);
    end else begin
      eff_cap = lmc_pkg::OCC_W'(cap_r);
    end
  end

  // ranks run 0..occ-1 without gaps, so the LRU entry holds rank occ-1
  assign lru_rank = lmc_pkg::RANK_W'(occ_r - lmc_pkg::OCC_W'(1));

  // parallel compare; keys are unique among valid entries, so one-hot
  always_comb begin
    for (int i = 0; i < N; i++) begin
      hit_oh[i]    = valid_r[i] && (key_r[i] == req.key);
      victim_oh[i] = valid_r[i] && (rank_r[i] == lru_rank);
    end
  end

  // lowest free slot
  assign free_oh = ~valid_r & (valid_r + N'(1));

  assign hit   = |hit_oh;
  assign evict = !hit && (occ_r >= eff_cap);
  assign slot_oh = evict ? victim_oh : free_oh;

  // one-hot read muxes
  always_comb begin
    hit_value  = '0;
    hit_rank   = '0;
    victim_key = '0;
    for (int i = 0; i < N; i++) begin
      if (hit_oh[i]) begin
        hit_value = hit_value | value_r[i];
        hit_rank  = hit_rank | rank_r[i];
      end
      if (victim_oh[i]) begin
        victim_key = victim_key | key_r[i];
      end
    end
  end

  // result of the item in the input register
  always_comb begin
    rsp.hit         = hit;
    rsp.value       = hit ? hit_value : req.fill;
    rsp.evicted     = evict;
    rsp.evicted_key = evict ? victim_key : '0;
  end

  // recency, valid and occupancy update
  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int i = 0; i < N; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (hit) begin
      for (int i = 0; i < N; i++) begin
        if (hit_oh[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
          rank_nxt[i] = rank_r[i] + lmc_pkg::RANK_W'(1);
        end
      end
    end else begin
      for (int i = 0; i < N; i++) begin
        if (slot_oh[i]) begin
          rank_nxt[i]  = '0;
          valid_nxt[i] = 1'b1;
        end else if (valid_r[i]) begin
          rank_nxt[i] = rank_r[i] + lmc_pkg::RANK_W'(1);
        end
      end
      if (!evict && (int'(occ_r) < N)) begin
        occ_nxt = occ_r + lmc_pkg::OCC_W'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      cap_r   <= lmc_pkg::CAP_RESET;
      for (int i = 0; i < N; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (commit) begin
        valid_r <= valid_nxt;
        occ_r   <= occ_nxt;
        for (int i = 0; i < N; i++) begin
          rank_r[i] <= rank_nxt[i];
        end
      end
    end
  end

  // key and value store, written on a miss
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (commit && !hit && slot_oh[i]) begin
        key_r[i]   <= req.key;
        value_r[i] <= req.fill;
      end
    end
  end

endmodule

`default_nettype wire

[design/lmc_checker.sv]
// Port-level checks for the LRU memo cache, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "lru_memo_cache_core_defines.svh"

module lmc_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tready,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [lmc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input wire logic [lmc_pkg::OUT_TUSER_W-1:0]    out_tuser
);

  logic                                              out_hit;
  logic                                              out_evict;
  logic [lmc_pkg::KEY_BITS-1:0]                      out_ekey;
  logic                                              out_stall;
  logic [lmc_pkg::OUT_TDATA_W+lmc_pkg::OUT_TUSER_W-1:0] out_word;

  // result fields as seen on the ports
  assign out_hit   = out_tuser[0];
  assign out_evict = out_tuser[1];
  assign out_ekey  = out_tdata[lmc_pkg::VALUE_BITS +: lmc_pkg::KEY_BITS];
  assign out_stall = out_tvalid && !out_tready;
  assign out_word  = {out_tdata, out_tuser};

  // a hit never evicts
  `LMC_ASSERT_NOW(a_hit_no_evict, out_tvalid && out_hit, !out_evict, "hit with eviction")

  // no eviction means a zero evicted key
  `LMC_ASSERT_NOW(a_key_zero, out_tvalid && !out_evict, out_ekey == '0, "evicted key not zero")

  // input side stalls only behind a stalled full output
  `LMC_ASSERT_NOW(a_stall_src, !in_tready, out_stall, "input stalled without output stall")

  // a stalled result holds
  `LMC_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_word), "stalled result changed")

endmodule

bind lru_memo_cache_core lmc_checker u_lmc_checker (.*);

`default_nettype wire

[bench/lru_cache_checker.sv]
// Scoreboard for the LRU memo cache: tracks cache contents and checks every result item
`timescale 1ns / 1ps

module lru_cache_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  input  logic                                 in_tready,
  input  logic [lmc_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic [lmc_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic [lmc_pkg::OUT_TUSER_W-1:0]      out_tuser,
  input  logic                                 cfg_wr_en,
  input  logic [lmc_pkg::CAP_W-1:0]            cfg_wr_data,
  output int                                   n_errors,
  output int                                   n_waiting
);
  import lmc_pkg::*;

  localparam int MAX_PRINTS = 50;

  // shadow copy of the cache
  logic [KEY_BITS-1:0]   slot_key   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] slot_value [MAX_ENTRIES];
  logic                  slot_valid [MAX_ENTRIES];
  int                    slot_age   [MAX_ENTRIES];
  int                    cache_occ;
  logic [CAP_W-1:0]      capacity_reg;

  rsp_t lookup_results[$];

  initial begin
    n_errors  = 0;
    n_waiting = 0;
  end

  task automatic report_error(input string msg);
    if (n_errors < MAX_PRINTS)
      $display("%0t ns: %s", $time, msg);
    n_errors++;
  endtask

  task automatic clear_cache();
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      slot_valid[i] = 1'b0;
      slot_age[i]   = 0;
      slot_key[i]   = '0;
      slot_value[i] = '0;
    end
    cache_occ    = 0;
    capacity_reg = CAP_RESET;
    lookup_results.delete();
  endtask

  // one lookup: hit refreshes recency, miss inserts (evicting the oldest when full)
  task automatic predict_lookup(input logic [KEY_BITS-1:0] key,
                                input logic [VALUE_BITS-1:0] fill,
                                output rsp_t r);
    int found;
    int slot;
    int best;
    int limit;
    int age;
    logic evict;
    logic [KEY_BITS-1:0] victim;
    found  = -1;
    slot   = -1;
    best   = 0;
    evict  = 1'b0;
    victim = '0;
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (found < 0 && slot_valid[i] && slot_key[i] == key)
        found = i;
    if (found >= 0) begin
      age = slot_age[found];
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (slot_valid[i] && slot_age[i] < age)
          slot_age[i]++;
      slot_age[found] = 0;
      r.hit         = 1'b1;
      r.value       = slot_value[found];
      r.evicted     = 1'b0;
      r.evicted_key = '0;
    end else begin
      // zero capacity acts as one, anything above the entry count as full size
      if (capacity_reg == 0)
        limit = 1;
      else if (capacity_reg > MAX_ENTRIES)
        limit = MAX_ENTRIES;
      else
        limit = capacity_reg;
      if (cache_occ >= limit) begin
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (slot_valid[i] && (slot < 0 || slot_age[i] > best)) begin
            slot = i;
            best = slot_age[i];
          end
        if (slot >= 0) begin
          evict  = 1'b1;
          victim = slot_key[slot];
          slot_valid[slot] = 1'b0;
        end
      end
      // no eviction: lowest free slot
      if (slot < 0) begin
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (slot < 0 && !slot_valid[i])
            slot = i;
        if (slot >= 0 && cache_occ < MAX_ENTRIES)
          cache_occ++;
      end
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (slot_valid[i])
          slot_age[i]++;
      if (slot >= 0) begin
        slot_key[slot]   = key;
        slot_value[slot] = fill;
        slot_valid[slot] = 1'b1;
        slot_age[slot]   = 0;
      end
      r.hit         = 1'b0;
      r.value       = fill;
      r.evicted     = evict;
      r.evicted_key = evict ? victim : '0;
    end
  endtask

  // watch all channels at each edge
  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (!rst_n) begin
      clear_cache();
    end else begin
      if (cfg_wr_en)
        capacity_reg = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        predict_lookup(in_tdata[KEY_BITS-1:0], in_tdata[KEY_BITS +: VALUE_BITS], want);
        lookup_results.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.value       = out_tdata[VALUE_BITS-1:0];
        got.evicted_key = out_tdata[VALUE_BITS +: KEY_BITS];
        got.hit         = out_tuser[0];
        got.evicted     = out_tuser[1];
        if (lookup_results.size() == 0) begin
          report_error($sformatf("result item with nothing expected: %p", got));
        end else begin
          want = lookup_results.pop_front();
          if (got.hit !== want.hit)
            report_error($sformatf("hit: got %b expected %b", got.hit, want.hit));
          if (got.value !== want.value)
            report_error($sformatf("result_value: got %h expected %h",
                                   got.value, want.value));
          if (got.evicted !== want.evicted)
            report_error($sformatf("evicted: got %b expected %b",
                                   got.evicted, want.evicted));
          if (got.evicted_key !== want.evicted_key)
            report_error($sformatf("evicted_key: got %h expected %h",
                                   got.evicted_key, want.evicted_key));
        end
      end
    end
    n_waiting <= lookup_results.size();
  end

endmodule

[bench/tb_top.sv]
// Stimulus and verdict for the LRU memo cache: directed lookups, then random capacity phases
`timescale 1ns / 1ps

module tb_top;
  import lmc_pkg::*;

  localparam int PHASE_ITEMS = 95;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_MAX    = 24;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;
  int n_errors;
  int n_waiting;

  // phase controls read by the receiver (quiet_mode also by the sender)
  logic quiet_mode = 1'b0;
  logic hold_req   = 1'b0;
  logic hold_taken = 1'b0;

  logic [KEY_BITS-1:0] key_pool[POOL_MAX];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  lru_memo_cache_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // lookup_key, fill_value
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),   // result_value, evicted_key
    .out_tuser   (out_tuser),   // hit, evicted
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)  // capacity
  );

  lru_cache_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .n_errors    (n_errors),
    .n_waiting   (n_waiting)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one lookup and hold it until taken
  task automatic send_lookup(input logic [KEY_BITS-1:0] key,
                             input logic [VALUE_BITS-1:0] fill);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {fill, key};
    do @(posedge clk); while (!in_tready);
    gap = quiet_mode ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // let every outstanding result drain, then settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (n_waiting != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // random lookups drawn mostly from a pool slightly larger than the capacity
  task automatic run_phase(input logic [CAP_W-1:0] cap);
    int pool_size;
    int r;
    logic [KEY_BITS-1:0] key;
    logic [VALUE_BITS-1:0] fill;
    write_capacity(cap);
    pool_size = (cap == 0) ? 1 : (cap > MAX_ENTRIES) ? MAX_ENTRIES : cap;
    pool_size = pool_size + $urandom_range(1, 6);
    if (pool_size > POOL_MAX) pool_size = POOL_MAX;
    for (int i = 0; i < POOL_MAX; i++)
      key_pool[i] = $urandom;
    key_pool[0] = (cap[0]) ? '1 : '0;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      key = (r < 80) ? key_pool[$urandom_range(0, pool_size - 1)] : $urandom;
      r = $urandom_range(0, 99);
      fill = (r < 5) ? '0 : (r < 10) ? '1 : $urandom;
      send_lookup(key, fill);
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int run;
    int gap;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    out_tready <= 1'b1;
    forever begin
      run = quiet_mode ? 16 : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      if (hold_req && !hold_taken) begin
        gap = HOLD_CYCLES;
        hold_taken = 1'b1;
      end else begin
        gap = quiet_mode ? 0 : pick_gap();
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // main sequence
  initial begin
    logic [CAP_W-1:0] phase_caps[10];
    phase_caps = '{5'd1, 5'd16, 5'd3, 5'd31, 5'd0, 5'd8, 5'd17, 5'd2, 5'd12, 5'd5};
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes at reset capacity, then hits that must return stored values
    send_lookup('0, '0);
    send_lookup('1, '1);
    send_lookup('0, 32'h1234_5678);
    send_lookup('1, '0);

    // capacity zero acts as one, and sits below current occupancy
    write_capacity(5'd0);
    send_lookup(32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_lookup('1, 32'hDEAD_BEEF);
    send_lookup(32'h0000_0001, 32'h0000_0002);

    // capacity above the entry count: fill every slot and force an eviction, then look up a kept key
    write_capacity(5'd31);
    for (int i = 0; i < 15; i++)
      send_lookup(32'h8000_0000 >> i, ~(32'h8000_0000 >> i));
    send_lookup(32'h0000_0001, '0);

    // random phases across capacity settings
    for (int p = 0; p < 10; p++) begin
      hold_req   = (p == 1);
      quiet_mode = (p == 4);
      run_phase(phase_caps[p]);
    end
    quiet_mode = 1'b0;

    wait_idle();
    repeat (10) @(posedge clk);
    if (n_errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
